FILE: sv/cqf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cqf_pkg
// Shared widths, constants, the arctangent table and the config bundle for
// the CORDIC cosine block with quadrant fold.
// ----------------------------------------------------------------------------
package cqf_pkg;

  // field and datapath widths
  localparam int ANG_W  = 32;   // input angle
  localparam int OUT_W  = 22;   // cosine result
  localparam int AB_W   = 13;   // angle scale register
  localparam int CB_W   = 20;   // cosine scale register
  localparam int CFG_W  = 20;   // config write data
  localparam int M_W    = 22;   // 360 * angle scale
  localparam int A_W    = 20;   // folded angle, at most 90 * angle scale
  localparam int P_W    = 40;   // folded angle * cosine scale
  localparam int Q_W    = 27;   // residual start value, at most 90 * cosine scale
  localparam int XW     = 24;   // CORDIC x / y
  localparam int ZW     = 29;   // CORDIC residual
  localparam int DW     = 26;   // per-step residual decrement
  localparam int PD_W   = 29;   // arctangent * cosine scale
  localparam int X0P_W  = 33;   // cosine scale * 6073

  localparam int MAX_STEPS = 9;

  // register indexes
  localparam logic REG_ANGLE_SCALE = 1'b0;
  localparam logic REG_COS_SCALE   = 1'b1;

  localparam logic [AB_W-1:0] ANGLE_SCALE_RST = 13'd10;
  localparam logic [CB_W-1:0] COS_SCALE_RST   = 20'd1000000;

  localparam logic [M_W-1:0] FULL_TURN = 22'd360;

  // start gain numerator (over 10000)
  localparam logic [X0P_W-1:0] GAIN_NUM = 33'd6073;

  // floor(v / 625) = (v * RECIP_625) >> 39, exact for v < 2^29
  localparam logic [29:0] RECIP_625 = 30'd879609303;
  // floor(v / 10) = (v * RECIP_10) >> 32, exact for v < 2^29
  localparam logic [28:0] RECIP_10  = 29'd429496730;

  // arctangent of 2^-i in tenths of a degree
  localparam logic [8:0] ATAN_TENTHS [10] = '{
    9'd450, 9'd266, 9'd140, 9'd71, 9'd36, 9'd18, 9'd9, 9'd4, 9'd2, 9'd1
  };

  // values derived from the config registers
  typedef struct packed {
    logic [AB_W-1:0]                 ab;   // angle scale, zero read as one
    logic [M_W-1:0]                  m;    // 360 * ab
    logic [CB_W-1:0]                 cb;   // cosine scale
    logic [A_W-1:0]                  x0;   // cb * 6073 / 10000
    logic [MAX_STEPS-1:0][DW-1:0]    d;    // atan_i * cb / 10
  } cqf_cfg_t;

  // signed shift right that rounds toward zero
  function automatic logic signed [XW-1:0] trunc_shift(
    input logic signed [XW-1:0] v,
    input int unsigned          sh
  );
    logic signed [XW-1:0] fl;
    fl = v >>> sh;
    if (v[XW-1] && ((fl <<< sh) != v)) begin
      trunc_shift = fl + XW'(1);
    end else begin
      trunc_shift = fl;
    end
  endfunction

endpackage

FILE: sv/cqf_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cqf_cfg
// Scale registers and the constants derived from them: full turn, start
// gain and the per-step residual decrements.
// ----------------------------------------------------------------------------
module cqf_cfg import cqf_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic             cfg_idx,
  input  logic [CFG_W-1:0] cfg_data,
  output cqf_cfg_t         cfg
);

  logic [AB_W-1:0]  angle_scale;
  logic [CB_W-1:0]  cos_scale;
  logic [AB_W-1:0]  ab_eff;
  logic [X0P_W-1:0] x0_prod;
  logic [58:0]      x0_full;
  logic [A_W-1:0]   x0;
  logic [PD_W-1:0]  d_prod [MAX_STEPS];
  logic [DW-1:0]    d_val  [MAX_STEPS];

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      angle_scale <= ANGLE_SCALE_RST;
      cos_scale   <= COS_SCALE_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_ANGLE_SCALE: angle_scale <= cfg_data[AB_W-1:0];
        REG_COS_SCALE:   cos_scale   <= cfg_data[CB_W-1:0];
        default:         angle_scale <= angle_scale;
      endcase
    end
  end

  // zero scale behaves as one
  assign ab_eff = (angle_scale == '0) ? AB_W'(1) : angle_scale;

  // start gain: cb * 6073 / 10000 as (cb * 6073 >> 4) / 625
  assign x0_full = 59'(x0_prod[X0P_W-1:4]) * 59'(RECIP_625);
  always_ff @(posedge clk) begin
    x0_prod <= X0P_W'(cos_scale) * GAIN_NUM;
    x0      <= x0_full[58:39];
  end

  // per-step decrements atan_i * cb / 10
  for (genvar i = 0; i < MAX_STEPS; i++) begin : g_dec
    logic [57:0] d_full;
    assign d_full = 58'(d_prod[i]) * 58'(RECIP_10);
    always_ff @(posedge clk) begin
      d_prod[i] <= PD_W'(cos_scale) * PD_W'(ATAN_TENTHS[i]);
      d_val[i]  <= d_full[57:32];
    end
    assign cfg.d[i] = d_val[i];
  end

  assign cfg.ab = ab_eff;
  assign cfg.m  = M_W'(ab_eff) * FULL_TURN;
  assign cfg.cb = cos_scale;
  assign cfg.x0 = x0;

endmodule

FILE: sv/cqf_divpipe.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cqf_divpipe
// Restoring divider, one quotient bit per register stage, one request
// entering per cycle. The caller must hold the divisor steady; not enforced.
// ----------------------------------------------------------------------------
module cqf_divpipe #(
  parameter int NUM_W = 32,
  parameter int DEN_W = 22
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic [NUM_W-1:0] in_num,
  input  logic [DEN_W-1:0] den,
  output logic             out_valid,
  output logic [NUM_W-1:0] out_quot,
  output logic [DEN_W-1:0] out_rem
);

  logic             vld [NUM_W+1];
  logic [NUM_W-1:0] num [NUM_W+1];
  logic [DEN_W-1:0] rem [NUM_W+1];

  assign vld[0] = in_valid;
  assign num[0] = in_num;
  assign rem[0] = '0;

  // one bit per stage: numerator shifts out the top, quotient in the bottom
  for (genvar k = 0; k < NUM_W; k++) begin : g_stage
    logic [DEN_W:0] trial;
    logic [DEN_W:0] diff;
    logic           fits;
    assign trial = {rem[k], num[k][NUM_W-1]};
    assign diff  = trial - {1'b0, den};
    assign fits  = trial >= {1'b0, den};
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else begin
        vld[k+1] <= vld[k];
      end
      num[k+1] <= {num[k][NUM_W-2:0], fits};
      rem[k+1] <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
    end
  end

  assign out_valid = vld[NUM_W];
  assign out_quot  = num[NUM_W];
  assign out_rem   = rem[NUM_W];

`ifndef ASSERT_OFF
  // remainder always lands below the divisor
  a_rem_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_rem < den))
    else $error("divider remainder not below divisor");
`endif

endmodule

FILE: sv/cqf_cordic.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cqf_cordic
// Rotation-mode CORDIC, one micro-rotation per register stage.
// ----------------------------------------------------------------------------
module cqf_cordic import cqf_pkg::*; #(
  parameter int STEPS = 9
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic signed [ZW-1:0] z0,
  input  cqf_cfg_t             cfg,
  output logic                 out_valid,
  output logic signed [XW-1:0] x_out
);

  logic                 vld [STEPS+1];
  logic                 s   [STEPS+1];   // 1: rotate positive
  logic signed [XW-1:0] x   [STEPS+1];
  logic signed [XW-1:0] y   [STEPS+1];
  logic signed [ZW-1:0] z   [STEPS+1];

  assign vld[0] = in_valid;
  assign s[0]   = 1'b1;
  assign x[0]   = XW'(cfg.x0);
  assign y[0]   = '0;
  assign z[0]   = z0;

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    logic signed [XW-1:0] tx, ty, xn, yn;
    logic signed [ZW-1:0] dz, zn;
    assign tx = trunc_shift(x[k], k);
    assign ty = trunc_shift(y[k], k);
    assign dz = {{(ZW-DW){1'b0}}, cfg.d[k]};
    // micro-rotation
    always_comb begin
      if (s[k]) begin
        xn = x[k] - ty;
        yn = y[k] + tx;
        zn = z[k] - dz;
      end else begin
        xn = x[k] + ty;
        yn = y[k] - tx;
        zn = z[k] + dz;
      end
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else begin
        vld[k+1] <= vld[k];
      end
      x[k+1] <= xn;
      y[k+1] <= yn;
      z[k+1] <= zn;
      s[k+1] <= (zn > 0);
    end
  end

  assign out_valid = vld[STEPS];
  assign x_out     = x[STEPS];

`ifndef ASSERT_OFF
  // every result matches a request that passed through every rotation stage
  a_step_latency: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $past(in_valid, STEPS))
    else $error("rotation pipeline produced an unmatched result");
`endif

endmodule

FILE: sv/cordic_cosine_with_quadrant_fold.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cordic_cosine_with_quadrant_fold
// Cosine of a scaled angle: modulo-360 reduction, quadrant fold, scaling of
// the residual, then CORDIC rotations.
// ----------------------------------------------------------------------------
// Throughput: one angle per cycle, every cycle; busy is low except just
// after reset, and the receiver cannot stall results.
// Depth is set by the two bit-serial dividers (32 and 40 stages) plus one
// stage per rotation.
// Reset: rst clears all valid bits, restores both scales; busy is high for
// the cycle following reset.
module cordic_cosine_with_quadrant_fold import cqf_pkg::*; #(
  parameter int CORDIC_STEPS = 9
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic signed [ANG_W-1:0] angle_in,
  input  logic                    cfg_we,
  input  logic                    cfg_idx,
  input  logic [CFG_W-1:0]        cfg_data,
  output logic                    done,
  output logic signed [OUT_W-1:0] cosine_out
);

  localparam int DIV1_W  = ANG_W;
  localparam int NEG_DLY = 1 + P_W + CORDIC_STEPS;
  localparam int LAT     = 1 + DIV1_W + 2 + P_W + CORDIC_STEPS + 1;

  cqf_cfg_t cfg;

  logic                 acc;
  logic                 abs_v;
  logic [ANG_W-1:0]     abs_ang;
  logic                 d1_v;
  logic [DIV1_W-1:0]    d1_q;
  logic [M_W-1:0]       d1_r;
  logic [M_W-2:0]       half;
  logic [M_W-3:0]       quarter;
  logic [M_W-1:0]       r1;
  logic [M_W-1:0]       r2;
  logic                 f_neg;
  logic                 fold_v;
  logic                 fold_neg;
  logic [A_W-1:0]       fold_a;
  logic                 prod_v;
  logic [P_W-1:0]       prod;
  logic                 d2_v;
  logic [P_W-1:0]       d2_q;
  logic [AB_W-1:0]      d2_r;
  logic signed [ZW-1:0] z0;
  logic                 c_v;
  logic signed [XW-1:0] c_x;
  logic [NEG_DLY-1:0]   neg_line;
  logic [OUT_W-1:0]     x_trunc;

  cqf_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .cfg      (cfg)
  );

  // request intake: magnitude of the angle
  assign acc = start & ~busy;
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b1;
      abs_v <= 1'b0;
    end else begin
      busy  <= 1'b0;
      abs_v <= acc;
    end
    abs_ang <= angle_in[ANG_W-1] ? (~angle_in + 1'b1) : angle_in;
  end

  // |angle| mod (360 * angle scale)
  cqf_divpipe #(.NUM_W(DIV1_W), .DEN_W(M_W)) u_mod (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (abs_v),
    .in_num    (abs_ang),
    .den       (cfg.m),
    .out_valid (d1_v),
    .out_quot  (d1_q),
    .out_rem   (d1_r)
  );

  // fold into the first quadrant, remember the sign flip
  assign half    = cfg.m[M_W-1:1];
  assign quarter = cfg.m[M_W-1:2];
  assign r1      = (d1_r > {1'b0, half}) ? (cfg.m - d1_r) : d1_r;
  assign f_neg   = r1 > {2'b00, quarter};
  assign r2      = f_neg ? ({1'b0, half} - r1) : r1;

  always_ff @(posedge clk) begin
    if (rst) begin
      fold_v <= 1'b0;
      prod_v <= 1'b0;
    end else begin
      fold_v <= d1_v;
      prod_v <= fold_v;
    end
    fold_a   <= r2[A_W-1:0];
    fold_neg <= f_neg;
    prod     <= P_W'(fold_a) * P_W'(cfg.cb);
  end

  // residual start value: folded angle * cos scale / angle scale
  cqf_divpipe #(.NUM_W(P_W), .DEN_W(AB_W)) u_scale (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (prod_v),
    .in_num    (prod),
    .den       (cfg.ab),
    .out_valid (d2_v),
    .out_quot  (d2_q),
    .out_rem   (d2_r)
  );

  assign z0 = {{(ZW-Q_W){1'b0}}, d2_q[Q_W-1:0]};

  cqf_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (d2_v),
    .z0        (z0),
    .cfg       (cfg),
    .out_valid (c_v),
    .x_out     (c_x)
  );

  // sign flag rides alongside the multiplier, divider and rotations
  always_ff @(posedge clk) begin
    neg_line <= {neg_line[NEG_DLY-2:0], fold_neg};
  end

  // output register
  assign x_trunc = c_x[OUT_W-1:0];
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= c_v;
    end
    cosine_out <= neg_line[NEG_DLY-1] ? (~x_trunc + 1'b1) : x_trunc;
  end

`ifndef ASSERT_OFF
  // each result matches an accepted request carried through the whole pipeline
  a_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(acc, LAT))
    else $error("result without a matching request");

  // cosine magnitude stays within the output range
  a_out_range: assert property (@(posedge clk) disable iff (rst)
    done |-> ((cosine_out <= 22'sd1100000) && (cosine_out >= -22'sd1100000)))
    else $error("cosine result out of range");

  // fold never leaves a remainder above half a turn (180 degrees)
  a_fold_range: assert property (@(posedge clk) disable iff (rst)
    d1_v |-> (r1 <= {1'b0, half}))
    else $error("fold left angle above half turn");
`endif

endmodule

FILE: tb/cordic_cosine_with_quadrant_fold_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cordic_cosine_with_quadrant_fold_tb
// Self-checking bench for the CORDIC cosine block. A short directed table
// covers the fold boundaries, the extreme angles and the scale corner cases.
// Random angles then run under several scale settings and sender gap rates.
// Each accepted request is predicted here, and the cosine is checked in
// order against the done strobe.
// ----------------------------------------------------------------------------
module cordic_cosine_with_quadrant_fold_tb;
  import cqf_pkg::*;

  localparam int LATENCY     = 85;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RAND_ITEMS  = 1900;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    start = 1'b0;
  logic                    busy;
  logic signed [ANG_W-1:0] angle_in = '0;
  logic                    cfg_we = 1'b0;
  logic                    cfg_idx = REG_ANGLE_SCALE;
  logic [CFG_W-1:0]        cfg_data = '0;
  logic                    done;
  logic signed [OUT_W-1:0] cosine_out;

  // scale registers as the block should hold them
  logic [AB_W-1:0] ang_scale_q = ANGLE_SCALE_RST;
  logic [CB_W-1:0] cos_scale_q = COS_SCALE_RST;

  logic signed [OUT_W-1:0] cos_pending[$];
  int errors = 0;
  int cycles = 0;
  int gap_pct = 0;

  // one row: either a scale write or an angle request
  typedef struct {
    bit                      is_cfg;
    logic                    idx;
    logic [CFG_W-1:0]        data;
    logic signed [ANG_W-1:0] ang;
    bit                      known;
    logic signed [OUT_W-1:0] cosv;
  } stim_row_t;

  stim_row_t dir_rows[$];

  cordic_cosine_with_quadrant_fold u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .angle_in(angle_in),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
    .done(done), .cosine_out(cosine_out)
  );

  always #1 clk = ~clk;

  // CORDIC cosine of one angle under the current scales
  function automatic logic signed [OUT_W-1:0] cosine_of(input logic signed [ANG_W-1:0] a_in);
    longint ab, cb, r, x, y, z, nx, ny, s, res;
    longint atan_t[10] = '{450, 266, 140, 71, 36, 18, 9, 4, 2, 1};
    bit neg;
    ab = (ang_scale_q == 0) ? 1 : longint'(ang_scale_q);
    cb = longint'(cos_scale_q);
    r = longint'(a_in) % (ab * 360);
    if (r < 0) r = -r;
    if (r > 180 * ab) r = 360 * ab - r;
    neg = (r > 90 * ab);
    if (neg) r = 180 * ab - r;
    x = cb * 6073 / 10000;
    y = 0;
    z = r * cb / ab;
    s = 1;
    for (int i = 0; i < MAX_STEPS; i++) begin
      nx = x - (s * y) / (longint'(1) << i);
      ny = y + (s * x) / (longint'(1) << i);
      z = z - (s * atan_t[i] * cb) / 10;
      x = nx;
      y = ny;
      s = (z > 0) ? 1 : -1;
    end
    res = neg ? -x : x;
    return OUT_W'(res);
  endfunction

  // predict at each accepted request
  always @(posedge clk) begin
    if (!rst && start && !busy) cos_pending.push_back(cosine_of(angle_in));
  end

  // check each result strobe against the oldest prediction
  always @(posedge clk) begin
    if (!rst && done) begin
      if (cos_pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result cosine_out=%0d", cosine_out);
      end else begin
        if (cosine_out !== cos_pending[0]) begin
          errors++;
          if (errors <= 10)
            $display("cosine mismatch: expected %0d got %0d", cos_pending[0], cosine_out);
        end
        void'(cos_pending.pop_front());
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("cordic_cosine_with_quadrant_fold regression: fail");
      $finish;
    end
  end

  // drain and let the pipeline settle before touching the scales
  task automatic wait_idle();
    start <= 1'b0;
    while (cos_pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  // one register write, then cfg_we drops so writes never abut
  task automatic write_scale(input logic idx, input logic [CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_ANGLE_SCALE) ang_scale_q = AB_W'(val);
    else cos_scale_q = CB_W'(val);
    @(posedge clk);
  endtask

  // present one request, with a random gap before it, until accepted
  task automatic send_angle(input logic signed [ANG_W-1:0] a);
    bit ok;
    if ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < gap_pct);
    end
    start <= 1'b1;
    angle_in <= a;
    forever begin
      @(negedge clk);
      ok = !busy;
      @(posedge clk);
      if (ok) break;
    end
  endtask

  function automatic logic signed [ANG_W-1:0] rand_angle();
    int unsigned ab, k;
    ab = (ang_scale_q == 0) ? 1 : ang_scale_q;
    k = $urandom_range(9);
    if (k < 3) return $urandom;
    if (k < 6) return ANG_W'($urandom_range(ab * 90) * ($urandom_range(8)) - 4 * ab * 90);
    // near fold boundaries
    return ANG_W'(int'($urandom_range(8)) * int'(ab * 90) * ($urandom_range(1) ? 1 : -1)
                  + int'($urandom_range(2)) - 1);
  endfunction

  function automatic stim_row_t cfg_row(input logic idx, input logic [CFG_W-1:0] v);
    stim_row_t r;
    r = '{1'b1, idx, v, '0, 1'b0, '0};
    return r;
  endfunction

  function automatic stim_row_t ang_row(input logic signed [ANG_W-1:0] a, input bit k,
                                        input logic signed [OUT_W-1:0] c);
    stim_row_t r;
    r = '{1'b0, REG_ANGLE_SCALE, '0, a, k, c};
    return r;
  endfunction

  initial begin
    int nph;
    // reset scales: angle in tenths of a degree
    dir_rows = '{
      ang_row(0, 0, 0), ang_row(900, 0, 0), ang_row(901, 0, 0), ang_row(1800, 0, 0),
      ang_row(1801, 0, 0), ang_row(2700, 0, 0), ang_row(3600, 0, 0), ang_row(-900, 0, 0),
      ang_row(-1800, 0, 0), ang_row(32'sh7FFFFFFF, 0, 0), ang_row(32'sh80000000, 0, 0),
      ang_row(-1, 0, 0),
      // zero cosine scale gives zero everywhere
      cfg_row(REG_COS_SCALE, 0), ang_row(450, 1, 0), ang_row(-1800, 1, 0),
      // zero angle scale acts as one; full-width cosine scale
      cfg_row(REG_ANGLE_SCALE, 0), cfg_row(REG_COS_SCALE, 20'hFFFFF),
      ang_row(90, 0, 0), ang_row(91, 0, 0), ang_row(179, 0, 0), ang_row(180, 0, 0),
      cfg_row(REG_ANGLE_SCALE, 13'h1FFF), ang_row(32'sh7FFFFFFF, 0, 0),
      ang_row(32'sh80000000, 0, 0), ang_row(8191 * 90, 0, 0)
    };
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table
    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) begin
        wait_idle();
        write_scale(dir_rows[i].idx, dir_rows[i].data);
      end else begin
        if (dir_rows[i].known && cosine_of(dir_rows[i].ang) !== dir_rows[i].cosv) begin
          errors++;
          if (errors <= 10) $display("table row %0d: predicted %0d, listed %0d", i,
                                     cosine_of(dir_rows[i].ang), dir_rows[i].cosv);
        end
        send_angle(dir_rows[i].ang);
      end
    end

    // random phases over scale settings and gap rates
    nph = 9;
    for (int p = 0; p < nph; p++) begin
      wait_idle();
      case (p)
        0: begin write_scale(REG_ANGLE_SCALE, 1);    write_scale(REG_COS_SCALE, 1); end
        1: begin write_scale(REG_ANGLE_SCALE, 4096); write_scale(REG_COS_SCALE, 1000000); end
        2: begin write_scale(REG_ANGLE_SCALE, 10);   write_scale(REG_COS_SCALE, 1000000); end
        3: begin write_scale(REG_ANGLE_SCALE, 8191); write_scale(REG_COS_SCALE, 20'hFFFFF); end
        4: begin write_scale(REG_ANGLE_SCALE, 0);    write_scale(REG_COS_SCALE, 0); end
        default: begin
          write_scale(REG_ANGLE_SCALE, $urandom_range(4096, 1));
          write_scale(REG_COS_SCALE, $urandom_range(1000000, 1));
        end
      endcase
      case (p % 3)
        0: gap_pct = 0;
        1: gap_pct = 84;
        default: gap_pct = 24;
      endcase
      for (int n = 0; n < RAND_ITEMS / nph; n++) send_angle(rand_angle());
    end

    // drain
    start <= 1'b0;
    while (cos_pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (errors == 0 && cos_pending.size() == 0) begin
      $display("cordic_cosine_with_quadrant_fold regression: pass");
    end else begin
      $display("cordic_cosine_with_quadrant_fold regression: fail");
    end
    $finish;
  end

endmodule

FILE: files.f
sv/cqf_pkg.sv
sv/cqf_cfg.sv
sv/cqf_divpipe.sv
sv/cqf_cordic.sv
sv/cordic_cosine_with_quadrant_fold.sv
tb/cordic_cosine_with_quadrant_fold_tb.sv
